[hw/rtl/mcfir_pkg.sv]
// ----------------------------------------------------------------------------
// mcfir_pkg: shared definitions of the multichannel FIR filter
// Field widths, request and register codes, channel payloads and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcfir_pkg;

  // Default sizing of the filter.
  localparam int FILTER_ORDER_DEF = 128;
  localparam int MAX_CHANNELS_DEF = 8;

  // Field widths.
  localparam int CHAN_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_IDX_W = 8;
  localparam int CNT_W      = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 4'd8;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic [CHAN_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [SAMPLE_W-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0]   filtered;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;   // write zero at the clearing address and advance
    logic accept;     // a request is taken from the input channel
    logic head_wr;    // store the sample at the channel's new head
    logic mac_issue;  // read one tap pair and advance
    logic round;      // round and saturate the accumulator
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_is_coef; // request at the input is a coefficient write
    logic in_filter;  // sample at the input goes through the filter
    logic clr_last;   // clearing address is the last one
    logic tap_last;   // tap counter is at the last tap
    logic pipe_busy;  // products still on their way to the accumulator
  } status_t;

endpackage

[hw/rtl/mcfir_stream_if.sv]
// ----------------------------------------------------------------------------
// mcfir_stream_if: valid/ready channel
// Carries one payload item per handshake, with source and sink views.
// ----------------------------------------------------------------------------
interface mcfir_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/mcfir_ram.sv]
// ----------------------------------------------------------------------------
// mcfir_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 129
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mcfir_ctrl.sv]
// ----------------------------------------------------------------------------
// mcfir_ctrl: sequencing controller
// Runs the clearing pass, takes requests, steps the tap walk and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mcfir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mcfir_pkg::status_t sts,
  output mcfir_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_is_coef) begin
            state_nxt = S_IDLE;
          end else if (sts.in_filter) begin
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HEAD: begin
        cmd.head_wr = 1'b1;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/mcfir_datapath.sv]
// ----------------------------------------------------------------------------
// mcfir_datapath: history and coefficient stores with one shared MAC
// Per-channel ring buffers in one RAM, a coefficient RAM, a registered
// multiplier, a wide accumulator and the round-and-saturate stage.
// ----------------------------------------------------------------------------
module mcfir_datapath #(
  parameter int FILTER_ORDER = mcfir_pkg::FILTER_ORDER_DEF,
  parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mcfir_pkg::in_item_t                in_item,
  input  logic                               cfg_we,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  mcfir_pkg::cmd_t                    cmd,
  output mcfir_pkg::status_t                 sts,
  output mcfir_pkg::out_item_t               out_item
);

  localparam int NUM_TAPS   = FILTER_ORDER + 1;
  localparam int TAP_AW     = $clog2(NUM_TAPS);
  localparam int HIST_DEPTH = MAX_CHANNELS * NUM_TAPS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CH_IW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW         = mcfir_pkg::SAMPLE_W;
  localparam int PROD_W     = 2 * SW;
  localparam int ACC_W      = PROD_W + TAP_AW;
  localparam int SUM_W      = ACC_W + 1;
  localparam int FRAC_W     = SW - 1;

  localparam logic signed [SW-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SW-1:0] SAT_MIN = 16'sh8000;

  // Configuration registers.
  logic                          filter_en_r;
  logic [mcfir_pkg::CNT_W-1:0]   chan_cnt_r;

  // Sequencing registers.
  logic [HIST_AW-1:0]            clr_cnt_r;
  logic [TAP_AW-1:0]             tap_cnt_r;
  logic [TAP_AW-1:0]             ptr_r;
  logic [TAP_AW-1:0]             head_r [MAX_CHANNELS];
  logic                          rd_v_r;
  logic                          prod_v_r;

  // Item and arithmetic registers.
  logic [mcfir_pkg::CHAN_W-1:0]  ch_r;
  logic signed [SW-1:0]          samp_r;
  logic signed [SW-1:0]          res_r;
  logic [HIST_AW-1:0]            base_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [mcfir_pkg::CHAN_W-1:0]  out_ch_r;
  logic signed [SW-1:0]          out_filt_r;

  logic [CH_IW-1:0]              head_idx;
  logic [TAP_AW-1:0]             head_cur;
  logic [TAP_AW-1:0]             head_new;
  logic                          coef_idx_ok;
  logic                          clr_in_coef;

  logic                          hist_we;
  logic [HIST_AW-1:0]            hist_waddr;
  logic [SW-1:0]                 hist_wdata;
  logic [HIST_AW-1:0]            hist_raddr;
  logic [SW-1:0]                 hist_q;
  logic                          coef_we;
  logic [TAP_AW-1:0]             coef_waddr;
  logic [SW-1:0]                 coef_wdata;
  logic [SW-1:0]                 coef_q;

  logic signed [SUM_W-1:0]       rnd_sum;
  logic signed [SW-1:0]          rnd_sat;

  // Status toward the controller.
  always_comb begin
    sts.in_is_coef = (in_item.req_type == mcfir_pkg::REQ_COEF);
    sts.in_filter  = filter_en_r
                     && ({1'b0, in_item.channel} < chan_cnt_r)
                     && (32'(in_item.channel) < MAX_CHANNELS);
    sts.clr_last   = (clr_cnt_r == HIST_AW'(HIST_DEPTH - 1));
    sts.tap_last   = (tap_cnt_r == TAP_AW'(NUM_TAPS - 1));
    sts.pipe_busy  = rd_v_r | prod_v_r;
  end

  // The ring head moves down by one for each new sample.
  assign head_idx    = CH_IW'(ch_r);
  assign head_cur    = head_r[head_idx];
  assign head_new    = (head_cur == '0) ? TAP_AW'(NUM_TAPS - 1) : head_cur - 1'b1;
  assign coef_idx_ok = (32'(in_item.coef_index) <= FILTER_ORDER);
  assign clr_in_coef = (32'(clr_cnt_r) < NUM_TAPS);

  // History RAM ports.
  assign hist_we    = cmd.clr_step | cmd.head_wr;
  assign hist_waddr = cmd.clr_step ? clr_cnt_r : base_r + HIST_AW'(head_new);
  assign hist_wdata = cmd.clr_step ? '0 : samp_r;
  assign hist_raddr = base_r + HIST_AW'(ptr_r);

  // Coefficient RAM ports.
  assign coef_we    = (cmd.clr_step && clr_in_coef)
                      || (cmd.accept && sts.in_is_coef && coef_idx_ok);
  assign coef_waddr = cmd.clr_step ? TAP_AW'(clr_cnt_r) : TAP_AW'(in_item.coef_index);
  assign coef_wdata = cmd.clr_step ? '0 : in_item.coef_value;

  mcfir_ram #(
    .WIDTH (SW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  mcfir_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (tap_cnt_r),
    .rdata (coef_q)
  );

  // Round half up at the Q1.15 point, then saturate to 16 bits.
  always_comb begin
    rnd_sum = SUM_W'(acc_r) + SUM_W'(16384);
    if (!rnd_sum[SUM_W-1] && (|rnd_sum[SUM_W-2:2*FRAC_W])) begin
      rnd_sat = SAT_MAX;
    end else if (rnd_sum[SUM_W-1] && !(&rnd_sum[SUM_W-2:2*FRAC_W])) begin
      rnd_sat = SAT_MIN;
    end else begin
      rnd_sat = rnd_sum[2*FRAC_W:FRAC_W];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      chan_cnt_r  <= mcfir_pkg::CHANNEL_COUNT_RST;
      clr_cnt_r   <= '0;
      tap_cnt_r   <= '0;
      ptr_r       <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mcfir_pkg::CFG_FILTER_ENABLE: filter_en_r <= cfg_wdata[0];
          mcfir_pkg::CFG_CHANNEL_COUNT: chan_cnt_r  <= cfg_wdata;
        endcase
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.head_wr) begin
        head_r[head_idx] <= head_new;
        ptr_r            <= head_new;
        tap_cnt_r        <= '0;
      end else if (cmd.mac_issue) begin
        ptr_r     <= (ptr_r == TAP_AW'(NUM_TAPS - 1)) ? '0 : ptr_r + 1'b1;
        tap_cnt_r <= tap_cnt_r + 1'b1;
      end
      rd_v_r   <= cmd.mac_issue;
      prod_v_r <= rd_v_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r   <= in_item.channel;
      samp_r <= in_item.sample;
      res_r  <= in_item.sample;
      base_r <= HIST_AW'(in_item.channel * NUM_TAPS);
    end else if (cmd.round) begin
      res_r <= rnd_sat;
    end
    if (rd_v_r) begin
      prod_r <= $signed(hist_q) * $signed(coef_q);
    end
    if (cmd.head_wr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_filt_r <= res_r;
    end
  end

  assign out_item.out_channel = out_ch_r;
  assign out_item.filtered    = out_filt_r;

endmodule

[hw/rtl/multichannel_fir_filter.sv]
// ----------------------------------------------------------------------------
// multichannel_fir_filter: interleaved multichannel FIR filter
// Each channel keeps its own sample history, all channels share one set of
// Q1.15 coefficients, and one multiply-accumulate walks the taps per sample.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Carries
//   in_if     in         valid / ready       sample or coefficient request
//   out_if    out        valid / ready       channel and filtered sample
//   cfg_*     in         write enable only   filter_enable, channel_count
//
// After a filtered sample is accepted, the shared multiplier reads one history and
// one coefficient word per cycle from the two RAMs; the pipeline then drains and
// the result is rounded before the next request is taken. A bypassed sample goes
// straight to the output register; a coefficient write keeps the block ready.
// After reset a clearing pass zeroes both RAMs, MAX_CHANNELS * (FILTER_ORDER + 1)
// history words (1032 by default), while in_if.ready stays low.
// The output register holds a result while the sink stalls; the block keeps
// taking requests and only waits when a new result is ready to be handed over.
//
module multichannel_fir_filter #(
  parameter int FILTER_ORDER = mcfir_pkg::FILTER_ORDER_DEF,
  parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mcfir_stream_if.sink                      in_if,
  mcfir_stream_if.source                    out_if,
  input  logic                              cfg_we,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Command and status bundles between the two halves.
  mcfir_pkg::cmd_t      cmd;
  mcfir_pkg::status_t   sts;
  mcfir_pkg::in_item_t  in_item;
  mcfir_pkg::out_item_t out_item;

  assign in_item        = in_if.payload;
  assign out_if.payload = out_item;

  // The controller owns both handshakes and the order of all RAM accesses.
  mcfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, both stores and the arithmetic.
  mcfir_datapath #(
    .FILTER_ORDER (FILTER_ORDER),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

[hw/rtl/mcfir_checker.sv]
// ----------------------------------------------------------------------------
// mcfir_checker: port-level checks of the multichannel FIR filter
// Watches the top-level handshakes over time; attached with a bind.
// ----------------------------------------------------------------------------
module mcfir_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_req_type,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mcfir_pkg::CHAN_W-1:0]     out_channel,
  input logic [mcfir_pkg::SAMPLE_W-1:0]   out_filtered
);

  // Reset leaves no result pending.
  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // Reset starts the clearing pass, so no request is taken right after it.
  a_reset_clearing: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request channel ready during the clearing pass");

  // A sample request occupies the block, so in_ready drops once it is taken.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == mcfir_pkg::REQ_SAMPLE) |=> !in_ready)
    else $error("request taken in the cycle after a sample");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
                                && $stable(out_filtered))
    else $error("stalled result changed");

endmodule

bind multichannel_fir_filter mcfir_checker u_mcfir_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_req_type  (in_if.payload.req_type),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_channel  (out_if.payload.out_channel),
  .out_filtered (out_if.payload.filtered)
);
